// ===== src/spsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Spiral scan position package
// Field widths, the walk result type and the corner mapping table shared by
// the spiral scan position unit and its ring walker.
// ----------------------------------------------------------------------------
package spsp_pkg;

  localparam int DIM_W  = 9;   // rows, cols and walk coordinates
  localparam int POS_W  = 17;  // position and cell number ports
  localparam int PROD_W = 18;  // product of two dimensions
  localparam int OFF_W  = 9;   // ring offset
  localparam int SEG_W  = 12;  // in-ring segment arithmetic

  // Bits of the corner mapping code.
  localparam int MAP_TRANSPOSE = 0;
  localparam int MAP_FLIP_ROW  = 1;
  localparam int MAP_FLIP_COL  = 2;

  typedef logic [2:0] map_t;

  typedef struct packed {
    logic [DIM_W-1:0] i;
    logic [DIM_W-1:0] j;
  } walk_res_t;

  // Maps {turn_sense, start_corner} onto a transpose and flips of a clockwise
  // walk from the top-left corner.
  function automatic map_t corner_map(input logic sense, input logic [1:0] corner);
    map_t m;
    m = 3'b000;
    unique case ({sense, corner})
      3'd0: m = 3'b000;
      3'd1: m = 3'b101;
      3'd2: m = 3'b110;
      3'd3: m = 3'b011;
      3'd4: m = 3'b001;
      3'd5: m = 3'b100;
      3'd6: m = 3'b111;
      3'd7: m = 3'b010;
      default: m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

// ===== src/spsp_ring_walk.sv =====
// ----------------------------------------------------------------------------
// Spiral scan ring walker
// Peels one outer ring per cycle off an h x w grid with a shared subtractor,
// then places the step inside the ring it falls in.
// ----------------------------------------------------------------------------
module spsp_ring_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [spsp_pkg::DIM_W-1:0]   h_in,
  input  logic [spsp_pkg::DIM_W-1:0]   w_in,
  input  logic [spsp_pkg::PROD_W-1:0]  p_in,
  output logic                         done,
  output spsp_pkg::walk_res_t          res
);

  logic                         active;
  logic [spsp_pkg::DIM_W-1:0]   h;
  logic [spsp_pkg::DIM_W-1:0]   w;
  logic [spsp_pkg::PROD_W-1:0]  p;
  logic [spsp_pkg::OFF_W-1:0]   off;

  logic [spsp_pkg::DIM_W:0]     hw_sum;
  logic [spsp_pkg::DIM_W+1:0]   ring;
  logic                         finish;
  logic [spsp_pkg::SEG_W-1:0]   h12, w12, o12, p12, ri, rj;
  spsp_pkg::walk_res_t          res_next;

  assign hw_sum = {1'b0, h} + {1'b0, w};
  assign ring   = {hw_sum, 1'b0} - (spsp_pkg::DIM_W+2)'(4);
  assign finish = (h == spsp_pkg::DIM_W'(1)) || (w == spsp_pkg::DIM_W'(1)) ||
                  (p < spsp_pkg::PROD_W'(ring));

  assign h12 = spsp_pkg::SEG_W'(h);
  assign w12 = spsp_pkg::SEG_W'(w);
  assign o12 = spsp_pkg::SEG_W'(off);
  assign p12 = p[spsp_pkg::SEG_W-1:0];

  // Position inside the current ring: a single row or column, else top, right, bottom, then left edge.
  always_comb begin
    priority if (h == spsp_pkg::DIM_W'(1)) begin
      ri = o12;
      rj = o12 + p12;
    end else if (w == spsp_pkg::DIM_W'(1)) begin
      ri = o12 + p12;
      rj = o12;
    end else if (p12 < w12) begin
      ri = o12;
      rj = o12 + p12;
    end else if (p12 < w12 + h12 - 12'd1) begin
      ri = o12 + p12 - w12 + 12'd1;
      rj = o12 + w12 - 12'd1;
    end else if (p12 < {w12[10:0], 1'b0} + h12 - 12'd2) begin
      ri = o12 + h12 - 12'd1;
      rj = o12 + {w12[10:0], 1'b0} + h12 - 12'd3 - p12;
    end else begin
      ri = o12 + spsp_pkg::SEG_W'(ring) - p12;
      rj = o12;
    end
    res_next.i = ri[spsp_pkg::DIM_W-1:0];
    res_next.j = rj[spsp_pkg::DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        h      <= h_in;
        w      <= w_in;
        p      <= p_in;
        off    <= '0;
      end else if (active) begin
        if (finish) begin
          active <= 1'b0;
          done   <= 1'b1;
          res    <= res_next;
        end else begin
          p   <= p - spsp_pkg::PROD_W'(ring);
          h   <= h - spsp_pkg::DIM_W'(2);
          w   <= w - spsp_pkg::DIM_W'(2);
          off <= off + spsp_pkg::OFF_W'(1);
        end
      end
    end
  end

endmodule

// ===== src/spiral_scan_position_unit.sv =====
// ----------------------------------------------------------------------------
// Spiral scan position unit
// Returns the row-major one-based cell number visited at a given step of an
// inward spiral walk over a rows x cols grid.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake       Ports
//  --------  --------------  ----------------------------------------------
//  query     start & !busy   rows, cols, turn_sense, start_corner, position
//  result    done (1 cycle)  cell_number, out_of_range
//
// After a query transfer busy stays high through the total and check states
// when the step is out of range; otherwise it stays high through those, the
// walk, in which the ring walker peels the full rings that lie before the
// requested step (at most (smaller dimension - 1) / 2), and the address and
// sum states. The result strobe follows in the first cycle with busy low
// again. The ring walker peels one ring per cycle.
// Reset is synchronous and active high; it returns the sequencer to idle and
// drops busy and done. The result is shown for exactly one cycle with done
// and cannot be held off; a new query may be transferred in that same cycle.
//
module spiral_scan_position_unit #(
  parameter int MAX_DIM = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [spsp_pkg::DIM_W-1:0]  rows,
  input  logic [spsp_pkg::DIM_W-1:0]  cols,
  input  logic                        turn_sense,
  input  logic [1:0]                  start_corner,
  input  logic [spsp_pkg::POS_W-1:0]  position,
  output logic                        done,
  output logic [spsp_pkg::POS_W-1:0]  cell_number,
  output logic                        out_of_range
);

  // Dimensions above MAX_DIM saturate; the ports cannot carry more than 511.
  localparam int DIM_MAX_PORT = (1 << spsp_pkg::DIM_W) - 1;
  localparam int CLAMP = (MAX_DIM < DIM_MAX_PORT) ? MAX_DIM : DIM_MAX_PORT;
  localparam logic [spsp_pkg::DIM_W-1:0] CLAMP_V = spsp_pkg::DIM_W'(CLAMP);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TOTAL = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_ADDR  = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;

  logic [2:0]                   state;
  logic [spsp_pkg::DIM_W-1:0]   rows_q, cols_q, r_q, c_q;
  logic [spsp_pkg::POS_W-1:0]   pos_q;
  spsp_pkg::map_t               map_q;
  logic [spsp_pkg::PROD_W-1:0]  mul_q;

  logic [spsp_pkg::DIM_W-1:0]   mul_a;
  logic [spsp_pkg::PROD_W-1:0]  mul_p;
  logic                         walk_start, walk_done;
  logic [spsp_pkg::DIM_W-1:0]   walk_h, walk_w, r_t, c_t, r_next, c_next;
  logic [spsp_pkg::PROD_W-1:0]  walk_p;
  spsp_pkg::walk_res_t          walk_res;
  logic [spsp_pkg::PROD_W-1:0]  sum;

  assign busy = (state != S_IDLE);

  // One multiplier serves both the grid size and the row offset.
  assign mul_a = (state == S_TOTAL) ? rows_q : r_q;
  assign mul_p = spsp_pkg::PROD_W'(mul_a) * spsp_pkg::PROD_W'(cols_q);

  // The walk is always clockwise from the top-left corner of a possibly
  // transposed grid; the result is mapped back afterwards.
  assign walk_start = (state == S_CHECK) &&
                      (spsp_pkg::PROD_W'(pos_q) <= mul_q);
  assign walk_h = map_q[spsp_pkg::MAP_TRANSPOSE] ? cols_q : rows_q;
  assign walk_w = map_q[spsp_pkg::MAP_TRANSPOSE] ? rows_q : cols_q;
  assign walk_p = spsp_pkg::PROD_W'(pos_q) - spsp_pkg::PROD_W'(1);

  spsp_ring_walk u_walk (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .h_in  (walk_h),
    .w_in  (walk_w),
    .p_in  (walk_p),
    .done  (walk_done),
    .res   (walk_res)
  );

  always_comb begin
    r_t    = map_q[spsp_pkg::MAP_TRANSPOSE] ? walk_res.j : walk_res.i;
    c_t    = map_q[spsp_pkg::MAP_TRANSPOSE] ? walk_res.i : walk_res.j;
    r_next = map_q[spsp_pkg::MAP_FLIP_ROW] ? (rows_q - spsp_pkg::DIM_W'(1) - r_t) : r_t;
    c_next = map_q[spsp_pkg::MAP_FLIP_COL] ? (cols_q - spsp_pkg::DIM_W'(1) - c_t) : c_t;
  end

  assign sum = mul_q + spsp_pkg::PROD_W'(c_q) + spsp_pkg::PROD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rows_q <= (rows > CLAMP_V) ? CLAMP_V : rows;
            cols_q <= (cols > CLAMP_V) ? CLAMP_V : cols;
            // Step zero is taken as the first step.
            pos_q  <= (position == '0) ? spsp_pkg::POS_W'(1) : position;
            map_q  <= spsp_pkg::corner_map(turn_sense, start_corner);
            state  <= S_TOTAL;
          end
        end
        S_TOTAL: begin
          mul_q <= mul_p;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (walk_start) begin
            state <= S_WALK;
          end else begin
            // Beyond the grid, including any grid with a zero dimension.
            done         <= 1'b1;
            cell_number  <= '0;
            out_of_range <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_done) begin
            r_q   <= r_next;
            c_q   <= c_next;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          mul_q <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          done         <= 1'b1;
          cell_number  <= sum[spsp_pkg::POS_W-1:0];
          out_of_range <= 1'b0;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/spiral_scan_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spiral scan position checker
// Watches the query and result channels of the spiral scan position unit,
// predicts the cell number of every accepted query and compares each result
// strobe, in order, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module spiral_scan_checker #(
  parameter int MAX_DIM = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [spsp_pkg::DIM_W-1:0]  rows,
  input  logic [spsp_pkg::DIM_W-1:0]  cols,
  input  logic                        turn_sense,
  input  logic [1:0]                  start_corner,
  input  logic [spsp_pkg::POS_W-1:0]  position,
  input  logic                        done,
  input  logic [spsp_pkg::POS_W-1:0]  cell_number,
  input  logic                        out_of_range,
  output int                          fail_count,
  output int                          pending_results
);

  localparam logic [1:0] CORNER_TOP_LEFT     = 2'd0;
  localparam logic [1:0] CORNER_TOP_RIGHT    = 2'd1;
  localparam logic [1:0] CORNER_BOTTOM_RIGHT = 2'd2;
  localparam logic [1:0] CORNER_BOTTOM_LEFT  = 2'd3;

  typedef struct packed {
    logic [spsp_pkg::POS_W-1:0] cell_no;
    logic                       beyond;
  } spiral_hit_t;

  spiral_hit_t expected_hits[$];

  // Any spiral is a clockwise spiral from the top-left corner, seen through a
  // transpose and row/column flips. The flips follow from the corner alone;
  // the walk is transposed when the sense disagrees with the corner's parity.
  function automatic spiral_hit_t locate_cell(input logic [spsp_pkg::DIM_W-1:0] rows_in,
                                              input logic [spsp_pkg::DIM_W-1:0] cols_in,
                                              input logic sense,
                                              input logic [1:0] corner,
                                              input logic [spsp_pkg::POS_W-1:0] pos_in);
    int unsigned grid_h, grid_w, step, h, w, off, lap, i, j, r, c;
    logic        transposed;
    spiral_hit_t hit;
    grid_h = (rows_in > MAX_DIM) ? MAX_DIM : rows_in;
    grid_w = (cols_in > MAX_DIM) ? MAX_DIM : cols_in;
    step   = (pos_in == 0) ? 1 : pos_in;
    hit.cell_no = '0;
    hit.beyond  = 1'b1;
    if (step > grid_h * grid_w) return hit;

    transposed = sense ^ corner[0];
    h = transposed ? grid_w : grid_h;
    w = transposed ? grid_h : grid_w;
    step = step - 1;
    off  = 0;
    // Peel whole rings until the step falls inside the current one.
    lap = 2 * (h + w) - 4;
    while (h > 1 && w > 1 && step >= lap) begin
      step = step - lap;
      h    = h - 2;
      w    = w - 2;
      off  = off + 1;
      lap  = 2 * (h + w) - 4;
    end
    if (h == 1) begin
      i = off;
      j = off + step;
    end else if (w == 1) begin
      i = off + step;
      j = off;
    end else if (step < w) begin
      i = off;
      j = off + step;
    end else if (step < w + h - 1) begin
      i = off + step - w + 1;
      j = off + w - 1;
    end else if (step < 2 * w + h - 2) begin
      i = off + h - 1;
      j = off + w - 1 - (step - (w + h - 2));
    end else begin
      i = off + h - 1 - (step - (2 * w + h - 3));
      j = off;
    end

    r = transposed ? j : i;
    c = transposed ? i : j;
    if (corner == CORNER_BOTTOM_RIGHT || corner == CORNER_BOTTOM_LEFT) r = grid_h - 1 - r;
    if (corner == CORNER_TOP_RIGHT || corner == CORNER_BOTTOM_RIGHT) c = grid_w - 1 - c;
    hit.cell_no = spsp_pkg::POS_W'(r * grid_w + c + 1);
    hit.beyond  = 1'b0;
    return hit;
  endfunction

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  always @(posedge clk) begin
    spiral_hit_t want;
    if (!rst) begin
      // A result never belongs to a query transferred at the same edge, so the
      // comparison comes before the new prediction is queued.
      if (done) begin
        if (expected_hits.size() == 0) begin
          $error("result with no query waiting: cell_number %0d out_of_range %0b",
                 cell_number, out_of_range);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          if (cell_number !== want.cell_no) begin
            $error("cell_number: expected %0d, actual %0d", want.cell_no, cell_number);
            fail_count++;
          end
          if (out_of_range !== want.beyond) begin
            $error("out_of_range: expected %0b, actual %0b", want.beyond, out_of_range);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        expected_hits.push_back(locate_cell(rows, cols, turn_sense, start_corner, position));
    end
    pending_results = expected_hits.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spiral scan position unit testbench
// Drives directed and random spiral queries through the command handshake and
// lets a separate checker predict and compare every result, then reports the
// verdict once all results have come back.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_DIM     = 256;
  // The drain tail outlasts the longest query, which grows with each peeled ring.
  localparam int DRAIN_TAIL  = 200;
  // Cycles without any transfer or result before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 78;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic [spsp_pkg::DIM_W-1:0]   rows;
  logic [spsp_pkg::DIM_W-1:0]   cols;
  logic                         turn_sense;
  logic [1:0]                   start_corner;
  logic [spsp_pkg::POS_W-1:0]   position;
  logic                         done;
  logic [spsp_pkg::POS_W-1:0]   cell_number;
  logic                         out_of_range;

  int fail_count;
  int pending_results;
  int sender_idle_pct;
  int quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  spiral_scan_position_unit #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .rows         (rows),
    .cols         (cols),
    .turn_sense   (turn_sense),
    .start_corner (start_corner),
    .position     (position),
    .done         (done),
    .cell_number  (cell_number),
    .out_of_range (out_of_range)
  );

  spiral_scan_checker #(
    .MAX_DIM(MAX_DIM)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .rows            (rows),
    .cols            (cols),
    .turn_sense      (turn_sense),
    .start_corner    (start_corner),
    .position        (position),
    .done            (done),
    .cell_number     (cell_number),
    .out_of_range    (out_of_range),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Watchdog: any query transfer or result strobe counts as progress. A long
  // stretch without either means the unit has stopped answering.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one query and holds it until it is transferred. Called at a
  // falling edge and returns at a falling edge. Idle cycles are drawn before
  // the query goes out; when none are drawn, start stays high from the last
  // transfer, so it is written only once per falling edge.
  task automatic send_query(input logic [spsp_pkg::DIM_W-1:0] r,
                            input logic [spsp_pkg::DIM_W-1:0] c,
                            input logic sense, input logic [1:0] corner,
                            input logic [spsp_pkg::POS_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    rows         <= r;
    cols         <= c;
    turn_sense   <= sense;
    start_corner <= corner;
    position     <= pos;
    // The transfer happens at the first rising edge that sees busy low.
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly small grids so the walks stay short, with a share of full-size,
  // oversized (saturating) and empty dimensions.
  function automatic logic [spsp_pkg::DIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70)      return spsp_pkg::DIM_W'($urandom_range(12, 1));
    else if (sel < 86) return spsp_pkg::DIM_W'($urandom_range(MAX_DIM, 1));
    else if (sel < 92) return spsp_pkg::DIM_W'($urandom_range(MAX_DIM, MAX_DIM - 1));
    else if (sel < 97) return spsp_pkg::DIM_W'($urandom_range(2 ** spsp_pkg::DIM_W - 1,
                                                              MAX_DIM + 1));
    else               return '0;
  endfunction

  // Most positions land inside the grid; the rest hit the last cells, step
  // zero, the cells just past the end, or anything the port can carry.
  task automatic send_random_query();
    logic [spsp_pkg::DIM_W-1:0] r, c;
    int unsigned                cells, pos;
    int                         sel;
    r = pick_dim();
    c = pick_dim();
    cells = ((r > MAX_DIM) ? MAX_DIM : r) * ((c > MAX_DIM) ? MAX_DIM : c);
    sel = $urandom_range(99);
    if (cells == 0 || sel >= 95)  pos = $urandom_range(2 ** spsp_pkg::POS_W - 1);
    else if (sel < 72)            pos = $urandom_range(cells, 1);
    else if (sel < 84)            pos = $urandom_range(cells + 1, cells - 1);
    else if (sel < 89)            pos = 0;
    else                          pos = $urandom_range(cells + 5, cells + 1);
    send_query(r, c, $urandom_range(1), $urandom_range(3), spsp_pkg::POS_W'(pos));
  endtask

  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    rows            = '0;
    cols            = '0;
    turn_sense      = 1'b0;
    start_corner    = '0;
    position        = '0;
    sender_idle_pct = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed queries, sent back to back.
    send_query(1, 1, $urandom_range(1), $urandom_range(3), 1);
    send_query(1, 1, $urandom_range(1), $urandom_range(3), 2);
    // Every sense and corner on one grid, at a step just past the second turn.
    for (int k = 0; k < 8; k++)
      send_query(4, 5, k[2], k[1:0], 9);
    send_query(MAX_DIM, MAX_DIM, $urandom_range(1), $urandom_range(3), MAX_DIM * MAX_DIM);
    send_query(MAX_DIM, MAX_DIM, $urandom_range(1), $urandom_range(3), MAX_DIM * MAX_DIM);
    send_query(MAX_DIM, MAX_DIM, $urandom_range(1), $urandom_range(3),
               2 ** spsp_pkg::POS_W - 1);
    send_query(MAX_DIM, MAX_DIM, $urandom_range(1), $urandom_range(3), 1);
    // Empty grids answer out of range for any step.
    send_query(0, 5, $urandom_range(1), $urandom_range(3), 1);
    send_query(7, 0, $urandom_range(1), $urandom_range(3), 3);
    // Dimensions beyond the maximum saturate to it.
    send_query(2 ** spsp_pkg::DIM_W - 1, 3, $urandom_range(1), $urandom_range(3), 700);
    send_query(3, 2 ** spsp_pkg::DIM_W - 1, $urandom_range(1), $urandom_range(3),
               3 * MAX_DIM);
    // Step zero behaves like step one.
    send_query(4, 5, $urandom_range(1), $urandom_range(3), 0);
    // Single row and single column walks, and the centers of a large and a small grid.
    send_query(1, 9, $urandom_range(1), $urandom_range(3), 6);
    send_query(9, 1, $urandom_range(1), $urandom_range(3), 6);
    send_query(MAX_DIM - 1, MAX_DIM, $urandom_range(1), $urandom_range(3),
               (MAX_DIM - 1) * MAX_DIM);
    send_query(6, 6, $urandom_range(1), $urandom_range(3), 36);

    // Hold off the next transfer until every outstanding result is back.
    start <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);

    // Random queries in three idling regimes: light, heavy, none.
    sender_idle_pct = 23;
    for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_random_query();
    sender_idle_pct = 73;
    for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_random_query();
    sender_idle_pct = 0;
    for (int n = 0; n < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3); n++) send_random_query();

    // Drain: the watchdog bounds this wait, the tail catches stray results.
    start <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== spiral_scan_position_unit.f =====
src/spsp_pkg.sv
src/spsp_ring_walk.sv
src/spiral_scan_position_unit.sv
tb/spiral_scan_checker.sv
tb/tb_top.sv
